@@ design/sha256_pkg.sv @@
// sha256_pkg: constants, round table and sigma functions of the sha-256 hasher
// depends on nothing; imported by the hasher top level and its checker

package sha256_pkg;

   localparam int COUNT_WIDTH = 61;
   localparam int DIGEST_WORDS = 8;
   localparam logic [2:0] LAST_WORD_INDEX = 3'(DIGEST_WORDS - 1);
   localparam logic [7:0] PAD_MARKER = 8'h80;
   localparam logic [5:0] LAST_BLOCK_BYTE = 6'd63;
   localparam logic [5:0] LAST_PAD_BYTE = 6'd55;
   localparam logic [5:0] LAST_ROUND = 6'd63;

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam logic [31:0] HASH_INIT [DIGEST_WORDS] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic logic [31:0] big_sigma0(input logic [31:0] x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic logic [31:0] big_sigma1(input logic [31:0] x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic logic [31:0] small_sigma0(input logic [31:0] x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic logic [31:0] small_sigma1(input logic [31:0] x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage

@@ design/sha256_message_hasher.sv @@
// sha256_message_hasher: byte-serial sha-256 engine, one round per cycle
// depends on sha256_pkg for the round table, initial hash and sigma functions
//
// throughput: one byte transaction per cycle while a block fills; the 64th byte
//    of a block runs the rounds on the shared round unit and one add before the next
//    transaction is taken; after the final transaction: padding bytes up to byte 55,
//    the length, the compression (padding and compression twice when the tail
//    leaves no room for the length), then eight digest words
// reset: synchronous, active high; hash returns to the initial values, byte, fill and round counters clear

module sha256_message_hasher
   import sha256_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // request channel: at most one message byte per transaction
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last_item,
   // response channel: eight digest words per message
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);

   typedef enum logic [2:0] {
      ST_IDLE,   // collecting message bytes
      ST_ROUND,  // one compression round per cycle
      ST_ADD,    // fold working variables into the hash
      ST_PAD,    // one padding byte per cycle
      ST_LEN,    // write the bit length into the last two words
      ST_OUT     // hand out the digest words
   } state_type;

   state_type state_ff, state_in;
   state_type ret_ff, ret_in;      // where to go once a compression is done

   logic [31:0] hash_ff [DIGEST_WORDS];
   logic [31:0] hash_in [DIGEST_WORDS];
   logic [31:0] vars_ff [DIGEST_WORDS];   // a..h
   logic [31:0] vars_in [DIGEST_WORDS];
   logic [31:0] window_ff [16];           // message schedule window, w[t]..w[t+15]
   logic [31:0] window_in [16];

   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [5:0]  fill_ff, fill_in;
   logic [5:0]  round_ff, round_in;
   logic        pad_first_ff, pad_first_in;
   logic [2:0]  out_idx_ff, out_idx_in;

   // shared round unit
   logic [31:0] t1, t2, sched_next;
   logic [63:0] bit_len;
   logic [7:0]  wr_byte;
   logic        wr_en;

   assign t1 = vars_ff[7] + big_sigma1(vars_ff[4])
             + ((vars_ff[4] & vars_ff[5]) ^ (~vars_ff[4] & vars_ff[6]))
             + ROUND_K[round_ff] + window_ff[0];
   assign t2 = big_sigma0(vars_ff[0])
             + ((vars_ff[0] & vars_ff[1]) ^ (vars_ff[0] & vars_ff[2])
                ^ (vars_ff[1] & vars_ff[2]));
   assign sched_next = small_sigma1(window_ff[14]) + window_ff[9]
                     + small_sigma0(window_ff[1]) + window_ff[0];

   assign bit_len = 64'(count_ff) << 3;

   // handshake and response fields
   assign req_ready       = (state_ff == ST_IDLE);
   assign rsp_valid       = (state_ff == ST_OUT);
   assign rsp_digest_word = hash_ff[out_idx_ff];
   assign rsp_word_index  = out_idx_ff;
   assign rsp_last_word   = (out_idx_ff == LAST_WORD_INDEX);

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      hash_in      = hash_ff;
      vars_in      = vars_ff;
      window_in    = window_ff;
      count_in     = count_ff;
      fill_in      = fill_ff;
      round_in     = round_ff;
      pad_first_in = pad_first_ff;
      out_idx_in   = out_idx_ff;
      wr_en        = 1'b0;
      wr_byte      = req_data_byte;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               pad_first_in = 1'b1;
               if (req_has_byte) begin
                  wr_en   = 1'b1;
                  fill_in = fill_ff + 6'd1;
                  if (count_ff != '1) begin
                     count_in = count_ff + 1'b1;
                  end
               end
               // a full block goes through compression before any padding
               if (req_has_byte && fill_ff == LAST_BLOCK_BYTE) begin
                  vars_in  = hash_ff;
                  round_in = '0;
                  state_in = ST_ROUND;
                  ret_in   = req_last_item ? ST_PAD : ST_IDLE;
               end else if (req_last_item) begin
                  state_in = ST_PAD;
               end
            end
         end
         ST_ROUND: begin
            for (int i = 7; i > 0; i--) begin
               vars_in[i] = vars_ff[i-1];
            end
            vars_in[4] = vars_ff[3] + t1;
            vars_in[0] = t1 + t2;
            for (int i = 0; i < 15; i++) begin
               window_in[i] = window_ff[i+1];
            end
            window_in[15] = sched_next;
            round_in      = round_ff + 6'd1;
            if (round_ff == LAST_ROUND) begin
               state_in = ST_ADD;
            end
         end
         ST_ADD: begin
            for (int i = 0; i < DIGEST_WORDS; i++) begin
               hash_in[i] = hash_ff[i] + vars_ff[i];
            end
            state_in = ret_ff;
         end
         ST_PAD: begin
            wr_en        = 1'b1;
            wr_byte      = pad_first_ff ? PAD_MARKER : 8'h00;
            pad_first_in = 1'b0;
            fill_in      = fill_ff + 6'd1;
            if (fill_ff == LAST_BLOCK_BYTE) begin
               // no room left for the length: compress and pad a further block
               vars_in  = hash_ff;
               round_in = '0;
               state_in = ST_ROUND;
               ret_in   = ST_PAD;
            end else if (fill_ff == LAST_PAD_BYTE) begin
               state_in = ST_LEN;
            end
         end
         ST_LEN: begin
            window_in[14] = bit_len[63:32];
            window_in[15] = bit_len[31:0];
            fill_in       = '0;
            vars_in       = hash_ff;
            round_in      = '0;
            out_idx_in    = '0;
            state_in      = ST_ROUND;
            ret_in        = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_ready) begin
               if (out_idx_ff == LAST_WORD_INDEX) begin
                  hash_in  = HASH_INIT;
                  count_in = '0;
                  state_in = ST_IDLE;
               end else begin
                  out_idx_in = out_idx_ff + 3'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // big-endian byte lane write into the current block word
      if (wr_en) begin
         unique case (fill_ff[1:0])
            2'd0: window_in[fill_ff[5:2]][31:24] = wr_byte;
            2'd1: window_in[fill_ff[5:2]][23:16] = wr_byte;
            2'd2: window_in[fill_ff[5:2]][15:8]  = wr_byte;
            2'd3: window_in[fill_ff[5:2]][7:0]   = wr_byte;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      window_ff  <= window_in;
      vars_ff    <= vars_in;
      out_idx_ff <= out_idx_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         ret_ff       <= ST_IDLE;
         hash_ff      <= HASH_INIT;
         count_ff     <= '0;
         fill_ff      <= '0;
         round_ff     <= '0;
         pad_first_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ret_ff       <= ret_in;
         hash_ff      <= hash_in;
         count_ff     <= count_in;
         fill_ff      <= fill_in;
         round_ff     <= round_in;
         pad_first_ff <= pad_first_in;
      end
   end

endmodule

@@ design/sha256_checker.sv @@
// sha256_checker: port-level assertions for the sha-256 hasher
// depends on sha256_pkg; bound to sha256_message_hasher below

module sha256_checker
   import sha256_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_digest_word,
   input logic [2:0]  rsp_word_index,
   input logic        rsp_last_word
);

   // a stalled digest word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_digest_word)
                                     && $stable(rsp_word_index)))
      else $error("digest word changed while stalled");

   // no new transaction taken while the digest is being handed out
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("request accepted during digest output");

   // digest words follow one another in order
   a_word_order: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last_word) |=>
         (rsp_valid && rsp_word_index == $past(rsp_word_index) + 3'd1))
      else $error("digest word index out of order");

   // the last flag marks the eighth word only
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_word == (rsp_word_index == LAST_WORD_INDEX)))
      else $error("last word flag mismatch");

   // after the last word the block is ready for the next message
   a_back_to_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_last_word) |=> (req_ready && !rsp_valid))
      else $error("not ready after digest output");

endmodule

bind sha256_message_hasher sha256_checker u_sha256_checker (.*);

@@ tb/tb.sv @@
// tb: self-checking bench for sha256_message_hasher, byte-serial sha-256 with digest output
// depends on design/sha256_message_hasher.sv (and its package) only; needs no files

`timescale 1ns / 100ps

module tb;

   // scoreboard types: one request transaction, one digest word
   typedef struct packed {
      logic [7:0] data;
      logic       has_byte;
      logic       last_item;
   } msg_item_type;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last_word;
   } digest_word_type;

   localparam int BYTE_COUNT_BITS = 61;
   localparam int RANDOM_ITEMS = 480;
   localparam int IDLE_PCT = 36;
   // window of cycles in which neither side idles at random
   localparam int BUSY_START = 1500;
   localparam int BUSY_STOP = 3500;
   localparam int HOLD_TRIGGER = 120;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 300;
   localparam int PRINT_LIMIT = 40;

   // standard sha-256 initial hash and round constants
   localparam logic [31:0] IV_WORDS [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_CONST [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   // every input starts at a known value
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_has_byte = 1'b0;
   logic        req_last_item = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   sha256_message_hasher dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_has_byte    (req_has_byte),
      .req_last_item   (req_last_item),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_digest_word (rsp_digest_word),
      .rsp_word_index  (rsp_word_index),
      .rsp_last_word   (rsp_last_word)
   );

   // stimulus and scoreboard storage
   msg_item_type    message_items[$];
   digest_word_type expected_digest[$];
   msg_item_type    next_item;
   digest_word_type wanted;

   // predictor state: running hash, block buffer, byte counter, fill position
   logic [31:0]                model_hash [8];
   logic [31:0]                model_block [16];
   logic [BYTE_COUNT_BITS-1:0] model_bytes;
   logic [5:0]                 model_fill;

   // counters shared between processes are updated with nonblocking assignments, error_count apart
   int unsigned cycle_count = 0;
   int unsigned items_accepted = 0;
   int unsigned words_checked = 0;
   int unsigned messages_checked = 0;
   int unsigned hold_left = 0;
   bit          hold_done = 1'b0;
   int unsigned error_count = 0;

   // stimulus statistics, gathered while the queue is filled
   int unsigned real_items = 0;
   int unsigned noise_items = 0;
   int unsigned messages_queued = 0;
   int unsigned long_tails = 0;
   int unsigned multi_block = 0;
   int unsigned message_bytes = 0;

   // 12 ns clock
   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [31:0] rotr(logic [31:0] x, int unsigned k);
      return (x >> k) | (x << (32 - k));
   endfunction

   function automatic void put_byte(int unsigned pos, logic [7:0] value);
      model_block[pos >> 2][(3 - (pos & 3)) * 8 +: 8] = value;
   endfunction

   // one 64-round compression of model_block into model_hash
   function automatic void compress_block();
      logic [31:0] sched [64];
      logic [31:0] v [8];
      logic [31:0] s0;
      logic [31:0] s1;
      logic [31:0] t1;
      logic [31:0] t2;
      for (int i = 0; i < 16; i++)
         sched[i] = model_block[i];
      for (int i = 16; i < 64; i++) begin
         s0 = rotr(sched[i-15], 7) ^ rotr(sched[i-15], 18) ^ (sched[i-15] >> 3);
         s1 = rotr(sched[i-2], 17) ^ rotr(sched[i-2], 19) ^ (sched[i-2] >> 10);
         sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
      end
      for (int i = 0; i < 8; i++)
         v[i] = model_hash[i];
      for (int i = 0; i < 64; i++) begin
         t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
            + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_CONST[i] + sched[i];
         t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
            + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6];
         v[6] = v[5];
         v[5] = v[4];
         v[4] = v[3] + t1;
         v[3] = v[2];
         v[2] = v[1];
         v[1] = v[0];
         v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++)
         model_hash[i] = model_hash[i] + v[i];
   endfunction

   function automatic void restart_message();
      for (int i = 0; i < 8; i++)
         model_hash[i] = IV_WORDS[i];
      model_bytes = '0;
      model_fill = '0;
   endfunction

   // takes one accepted transaction; on the final one queues the eight digest words
   function automatic void absorb_item(msg_item_type item);
      int unsigned     pos;
      logic [63:0]     bit_len;
      digest_word_type w;
      if (item.has_byte) begin
         put_byte(model_fill, item.data);
         model_fill = model_fill + 6'd1;
         if (model_bytes != '1)
            model_bytes = model_bytes + 1'b1;
         if (model_fill == '0)
            compress_block();
      end
      if (!item.last_item)
         return;
      // padding: marker, zeros, then the 64-bit bit length
      pos = model_fill;
      put_byte(pos, 8'h80);
      pos++;
      if (pos > 56) begin
         // long tail: no room for the length, so an extra block goes first
         while (pos < 64) begin
            put_byte(pos, 8'h00);
            pos++;
         end
         compress_block();
         pos = 0;
      end
      while (pos < 56) begin
         put_byte(pos, 8'h00);
         pos++;
      end
      bit_len = {model_bytes, 3'b000};
      model_block[14] = bit_len[63:32];
      model_block[15] = bit_len[31:0];
      compress_block();
      for (int i = 0; i < 8; i++) begin
         w.word = model_hash[i];
         w.index = 3'(i);
         w.last_word = (i == 7);
         expected_digest.push_back(w);
      end
      restart_message();
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic void push_item(logic [7:0] data, logic has_byte, logic last_item);
      msg_item_type item;
      item.data = data;
      item.has_byte = has_byte;
      item.last_item = last_item;
      message_items.push_back(item);
      if (has_byte || last_item)
         real_items++;
      else
         noise_items++;
   endfunction

   // a message of random bytes; the final transaction either carries a byte or none,
   // and ignored transactions are sprinkled in at noise_pct percent
   function automatic void queue_message(int unsigned len, bit byte_on_last,
                                         int unsigned noise_pct);
      int unsigned body;
      body = (len != 0 && byte_on_last) ? len - 1 : len;
      for (int unsigned i = 0; i < body; i++) begin
         if ($urandom_range(99) < noise_pct)
            push_item(8'($urandom), 1'b0, 1'b0);
         push_item(8'($urandom), 1'b1, 1'b0);
      end
      if ($urandom_range(99) < noise_pct)
         push_item(8'($urandom), 1'b0, 1'b0);
      push_item(8'($urandom), len != 0 && byte_on_last, 1'b1);
      messages_queued++;
      message_bytes += len;
      if (len % 64 >= 56)
         long_tails++;
      if (len >= 64)
         multi_block++;
   endfunction

   function automatic int unsigned pick_length();
      int unsigned r;
      r = $urandom_range(99);
      // mostly short messages; a band around the long tail and block boundary; some long ones
      if (r < 55)
         return $urandom_range(12);
      else if (r < 80)
         return $urandom_range(54, 13);
      else if (r < 95)
         return $urandom_range(66, 55);
      else
         return $urandom_range(200, 100);
   endfunction

   // random idling outside the busy window
   function automatic bit take_idle();
      if (cycle_count >= BUSY_START && cycle_count < BUSY_STOP)
         return 1'b0;
      return $urandom_range(99) < IDLE_PCT;
   endfunction

   task automatic report_mismatch(string what, logic [31:0] want_v, logic [31:0] got_v);
      error_count++;
      if (error_count <= PRINT_LIMIT)
         $display("mismatch at %0t ns: %s, expected %h, got %h", $time, what, want_v, got_v);
   endtask

   // ---------------------------------------------------------------- driver

   // a new transaction is offered only once the previous one has gone
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_item('{req_data_byte, req_has_byte, req_last_item});
            items_accepted <= items_accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (message_items.size() != 0 && !take_idle()) begin
               next_item = message_items.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= next_item.data;
               req_has_byte <= next_item.has_byte;
               req_last_item <= next_item.last_item;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   // long receiver hold-off, once, while the sender still has plenty queued
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && items_accepted >= HOLD_TRIGGER) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_digest.size() == 0) begin
               report_mismatch("digest word with none expected", 32'h0, rsp_digest_word);
            end else begin
               wanted = expected_digest.pop_front();
               if (rsp_digest_word !== wanted.word)
                  report_mismatch("digest_word", wanted.word, rsp_digest_word);
               if (rsp_word_index !== wanted.index)
                  report_mismatch("word_index", 32'(wanted.index), 32'(rsp_word_index));
               if (rsp_last_word !== wanted.last_word)
                  report_mismatch("last_word", 32'(wanted.last_word), 32'(rsp_last_word));
               if (wanted.last_word)
                  messages_checked <= messages_checked + 1;
            end
            words_checked <= words_checked + 1;
         end
         rsp_ready <= (hold_left == 0) && !take_idle();
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin
      restart_message();
      for (int i = 0; i < 16; i++)
         model_block[i] = '0;

      // directed: empty message, ignored transactions, byte on the final
      // transaction or not, and the extreme byte values
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'hff, 1'b0, 1'b0);
      push_item(8'h5a, 1'b0, 1'b1);
      push_item(8'h61, 1'b1, 1'b0);
      push_item(8'h62, 1'b1, 1'b0);
      push_item(8'h63, 1'b1, 1'b1);
      push_item(8'hff, 1'b1, 1'b0);
      push_item(8'h00, 1'b0, 1'b1);
      push_item(8'h00, 1'b1, 1'b1);
      push_item(8'hff, 1'b1, 1'b0);
      push_item(8'h3c, 1'b0, 1'b0);
      push_item(8'h00, 1'b1, 1'b1);
      messages_queued += 6;
      message_bytes += 7;

      // random: start on the padding boundaries, then random lengths
      queue_message(55, 1'b1, 5);
      queue_message(56, 1'b0, 5);
      queue_message(63, 1'b1, 5);
      queue_message(64, 1'b0, 5);
      while (real_items < RANDOM_ITEMS + 12)
         queue_message(pick_length(), 1'($urandom_range(1)), 8);

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // drain: stimulus gone, then every digest word back, then a quiet spell
      while (message_items.size() != 0 || req_valid)
         @(posedge clock);
      while (expected_digest.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d messages, %0d message bytes, %0d ignored transactions",
               messages_queued, message_bytes, noise_items);
      $display("including %0d long tails and %0d multi-block messages; %0d digests checked",
               long_tails, multi_block, messages_checked);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // timeout, far beyond the slowest correct run
   initial begin
      #4000000;
      $display("timeout with %0d digest words outstanding", expected_digest.size());
      $display("FAIL");
      $finish;
   end

endmodule
